[rtl/sebc_pkg.sv]
// ----------------------------------------------------------------------------
// sebc_pkg
// Shared widths, register codes, reset values and stage control type for the
// Sobel edge binarizer with per-frame edge count.
// ----------------------------------------------------------------------------
package sebc_pkg;

   localparam int PIX_W          = 8;
   localparam int COUNT_W        = 23;
   localparam int WIDTH_REG_W    = 12;
   localparam int HEIGHT_REG_W   = 13;
   localparam int THR_W          = 11;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 13;
   localparam int REQ_DATA_W     = 8;
   localparam int RSP_DATA_W     = 32;
   localparam int GRAD_W         = 11;
   localparam int ABS_W          = 10;
   localparam int MAG_W          = 11;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd480;
   localparam logic [THR_W-1:0]        THR_RST    = 11'd90;

   localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
   localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH    = 2'd0,
      CSR_FRAME_HEIGHT   = 2'd1,
      CSR_EDGE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

endpackage

[rtl/sebc_csr.sv]
// ----------------------------------------------------------------------------
// sebc_csr
// Configuration registers and the clamped last column and last row limits.
// ----------------------------------------------------------------------------
module sebc_csr #(
   parameter int MAX_WIDTH  = sebc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sebc_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sebc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sebc_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic [$clog2(MAX_WIDTH)-1:0]        col_last,
   output logic [$clog2(MAX_HEIGHT)-1:0]       row_last,
   output logic [sebc_pkg::THR_W-1:0]          threshold
);
   import sebc_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WCW   = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;
   localparam int HCW   = (ROW_W + 1 > HEIGHT_REG_W) ? ROW_W + 1 : HEIGHT_REG_W;
   localparam logic [WCW-1:0] WIDTH_HI  = WCW'(MAX_WIDTH);
   localparam logic [HCW-1:0] HEIGHT_HI = HCW'(MAX_HEIGHT);

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [THR_W-1:0]        thr_ff;
   logic [WCW-1:0]          width_ext;
   logic [HCW-1:0]          height_ext;
   logic [WCW-1:0]          col_last_full;
   logic [HCW-1:0]          row_last_full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         thr_ff    <= THR_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_ff <= csr_data[WIDTH_REG_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               height_ff <= csr_data[HEIGHT_REG_W-1:0];
            end
            CSR_EDGE_THRESHOLD: begin
               thr_ff <= csr_data[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign width_ext  = WCW'(width_ff);
   assign height_ext = HCW'(height_ff);

   always_comb begin
      if (width_ext < WCW'(3)) begin
         col_last_full = WCW'(2);
      end else if (width_ext > WIDTH_HI) begin
         col_last_full = WIDTH_HI - WCW'(1);
      end else begin
         col_last_full = width_ext - WCW'(1);
      end
      if (height_ext < HCW'(3)) begin
         row_last_full = HCW'(2);
      end else if (height_ext > HEIGHT_HI) begin
         row_last_full = HEIGHT_HI - HCW'(1);
      end else begin
         row_last_full = height_ext - HCW'(1);
      end
   end

   assign col_last  = col_last_full[COL_W-1:0];
   assign row_last  = row_last_full[ROW_W-1:0];
   assign threshold = thr_ff;

endmodule

[rtl/sebc_line_store.sv]
// ----------------------------------------------------------------------------
// sebc_line_store
// Two line stores packed into one memory word per column: the low byte holds
// the line two up and the high byte the line one up. One read, one write.
// ----------------------------------------------------------------------------
module sebc_line_store #(
   parameter int MAX_WIDTH = sebc_pkg::MAX_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
   output logic [2*sebc_pkg::PIX_W-1:0]     rd_data,
   input  logic                             wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]     wr_addr,
   input  logic [2*sebc_pkg::PIX_W-1:0]     wr_data
);
   import sebc_pkg::*;

   logic [2*PIX_W-1:0] mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sebc_sobel.sv]
// ----------------------------------------------------------------------------
// sebc_sobel
// 3x3 window and the gradient stage: horizontal and vertical Sobel sums are
// formed from the window and registered as absolute values.
// ----------------------------------------------------------------------------
module sebc_sobel (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            shift_en,
   input  logic                            adv1,
   input  logic                            adv2,
   input  sebc_pkg::stage_ctl_type         ctl_in,
   input  logic [sebc_pkg::PIX_W-1:0]      pix,
   input  logic [sebc_pkg::PIX_W-1:0]      top,
   input  logic [sebc_pkg::PIX_W-1:0]      mid,
   output sebc_pkg::stage_ctl_type         s1_ctl,
   output sebc_pkg::stage_ctl_type         s2_ctl,
   output logic [sebc_pkg::ABS_W-1:0]      gx_abs,
   output logic [sebc_pkg::ABS_W-1:0]      gy_abs
);
   import sebc_pkg::*;

   logic [PIX_W-1:0]        win_ff [9];
   logic signed [GRAD_W-1:0] p [9];
   logic signed [GRAD_W-1:0] gx;
   logic signed [GRAD_W-1:0] gy;
   logic signed [GRAD_W-1:0] gx_mag;
   logic signed [GRAD_W-1:0] gy_mag;
   stage_ctl_type           s1_ctl_ff;
   stage_ctl_type           s2_ctl_ff;
   logic [ABS_W-1:0]        gx_abs_ff;
   logic [ABS_W-1:0]        gy_abs_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= top;
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= mid;
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= pix;
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         p[i] = signed'({{(GRAD_W - PIX_W){1'b0}}, win_ff[i]});
      end
      gx = (p[2] - p[0]) + ((p[5] - p[3]) <<< 1) + (p[8] - p[6]);
      gy = (p[0] - p[6]) + ((p[1] - p[7]) <<< 1) + (p[2] - p[8]);
      gx_mag = gx[GRAD_W-1] ? -gx : gx;
      gy_mag = gy[GRAD_W-1] ? -gy : gy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
      end else begin
         if (adv1) begin
            s1_ctl_ff <= shift_en ? ctl_in : '0;
         end
         if (adv2) begin
            s2_ctl_ff <= s1_ctl_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         gx_abs_ff <= gx_mag[ABS_W-1:0];
         gy_abs_ff <= gy_mag[ABS_W-1:0];
      end
   end

   assign s1_ctl = s1_ctl_ff;
   assign s2_ctl = s2_ctl_ff;
   assign gx_abs = gx_abs_ff;
   assign gy_abs = gy_abs_ff;

endmodule

[rtl/sobel_edge_binarize_count_top.sv]
// ----------------------------------------------------------------------------
// sobel_edge_binarize_count_top
// 3x3 Sobel edge detector on a raster luma stream with threshold binarization
// and a running per-frame edge count.
//
// Channel  Direction  Payload
// req      in         tdata[7:0] luma
// rsp      out        tdata[7:0] edge_value, tdata[30:8] edge_count, tlast
// csr      in         index 0 width, 1 height, 2 threshold; data[12:0]
//
// One pixel is taken per clock cycle unless the output stalls; its result is
// registered in the window, the gradient stage and the output register. The line
// store memory gives one read and one write per cycle, which sets the rate. Its
// contents are not cleared at reset, so no clearing pass is needed. A stalled
// result stalls the input only once both internal stages and the output
// register are full.
// ----------------------------------------------------------------------------
module sobel_edge_binarize_count_top #(
   parameter int MAX_WIDTH  = sebc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sebc_pkg::MAX_HEIGHT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sebc_pkg::REQ_DATA_W-1:0]    req_tdata,  // [7:0] luma
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sebc_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [7:0] edge_value, [30:8] edge_count
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sebc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sebc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sebc_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   logic [COL_W-1:0]   col_last;
   logic [ROW_W-1:0]   row_last;
   logic [THR_W-1:0]   threshold;
   logic [COL_W-1:0]   column_ff;
   logic [COL_W-1:0]   column_in;
   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   row_in;
   logic               accept;
   logic               line_end;
   logic               frame_end;
   logic [2*PIX_W-1:0] rd_data;
   logic [2*PIX_W-1:0] wr_data;
   stage_ctl_type      ctl_in;
   stage_ctl_type      s1_ctl;
   stage_ctl_type      s2_ctl;
   logic [ABS_W-1:0]   gx_abs;
   logic [ABS_W-1:0]   gy_abs;
   logic               adv1;
   logic               adv2;
   logic               adv_out;
   logic [MAG_W-1:0]   mag;
   logic               is_edge;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   rsp_value_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_last_ff;

   sebc_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .col_last  (col_last),
      .row_last  (row_last),
      .threshold (threshold)
   );

   assign adv_out    = !rsp_valid_ff || rsp_tready;
   assign adv2       = !s2_ctl.valid || adv_out;
   assign adv1       = !s1_ctl.valid || adv2;
   assign req_tready = adv1;
   assign accept     = req_tvalid && adv1;

   assign line_end  = column_ff >= col_last;
   assign frame_end = line_end && (row_ff >= row_last);

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept) begin
         if (frame_end) begin
            column_in = '0;
            row_in    = '0;
         end else if (line_end) begin
            column_in = '0;
            row_in    = row_ff + ROW_W'(1);
         end else begin
            column_in = column_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   // The read address follows the next column, so the word for the current
   // column is always ready when its pixel arrives.
   assign wr_data = {req_tdata[PIX_W-1:0], rd_data[2*PIX_W-1:PIX_W]};

   sebc_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_addr (column_in),
      .rd_data (rd_data),
      .wr_en   (accept),
      .wr_addr (column_ff),
      .wr_data (wr_data)
   );

   assign ctl_in.valid = (column_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2));
   assign ctl_in.last  = frame_end;

   sebc_sobel u_sobel (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept),
      .adv1     (adv1),
      .adv2     (adv2),
      .ctl_in   (ctl_in),
      .pix      (req_tdata[PIX_W-1:0]),
      .top      (rd_data[PIX_W-1:0]),
      .mid      (rd_data[2*PIX_W-1:PIX_W]),
      .s1_ctl   (s1_ctl),
      .s2_ctl   (s2_ctl),
      .gx_abs   (gx_abs),
      .gy_abs   (gy_abs)
   );

   assign mag     = MAG_W'(gx_abs) + MAG_W'(gy_abs);
   assign is_edge = mag > threshold;

   always_comb begin
      count_in = count_ff;
      if (is_edge && (count_ff != '1)) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else if (adv_out) begin
         rsp_valid_ff <= s2_ctl.valid;
         if (s2_ctl.valid) begin
            count_ff <= s2_ctl.last ? '0 : count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out && s2_ctl.valid) begin
         rsp_value_ff <= is_edge ? EDGE_ON : EDGE_OFF;
         rsp_count_ff <= count_in;
         rsp_last_ff  <= s2_ctl.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - COUNT_W - PIX_W){1'b0}}, rsp_count_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Sobel edge binarizer with per-frame edge count.
// A short scripted sequence covers size clamping, the strict threshold
// compare, a register write in the middle of a frame and the end of a frame.
// Random frames of various sizes and textures follow. Each result is compared
// with its scripted value, if any, else with a behavioral model of the window,
// line stores and counters kept in the bench. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
   import sebc_pkg::*;

   localparam int                   DRAIN_CYCLES  = 8;
   localparam int                   SETTLE_CYCLES = 20;
   localparam int                   STALL_LIMIT   = 2000;
   localparam int                   RANDOM_PIXELS = 1050;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE     = 2'd3;

   typedef enum int {
      TEXTURE_NOISE,
      TEXTURE_SMOOTH,
      TEXTURE_BINARY,
      TEXTURE_SPIKES
   } texture_type;

   typedef struct packed {
      logic [PIX_W-1:0]   edge_value;
      logic [COUNT_W-1:0] edge_count;
      logic               last_of_frame;
   } edge_result_type;

   typedef struct packed {
      logic                  is_write;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] value;
      logic                  has_result;
      edge_result_type       result;
   } script_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   logic [PIX_W-1:0]        line_mem [2*MAX_WIDTH_DEF];
   logic [PIX_W-1:0]        sobel_win [9];
   logic [10:0]             col_pos     = '0;
   logic [11:0]             row_pos     = '0;
   logic [COUNT_W-1:0]      frame_edges = '0;
   logic [WIDTH_REG_W-1:0]  cfg_width   = WIDTH_RST;
   logic [HEIGHT_REG_W-1:0] cfg_height  = HEIGHT_RST;
   logic [THR_W-1:0]        cfg_thr     = THR_RST;

   edge_result_type expected_edges[$];
   int              mismatches    = 0;
   int              idle_cycles   = 0;
   int              random_pixels = 0;
   int              rsp_hold      = 0;
   int              luma_walk     = 128;
   logic            req_quiet     = 1'b0;
   logic            rsp_quiet     = 1'b0;

   sobel_edge_binarize_count_top dut (.*);

   always #4 clock = ~clock;

   function automatic int pick_gap(input logic quiet);
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic script_row_type wr(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] data);
      return '{is_write: 1'b1, reg_index: idx, value: data, has_result: 1'b0, result: '0};
   endfunction

   function automatic script_row_type px(input logic [PIX_W-1:0] luma);
      return '{is_write: 1'b0, reg_index: '0, value: CSR_DATA_W'(luma), has_result: 1'b0,
               result: '0};
   endfunction

   function automatic script_row_type pxe(input logic [PIX_W-1:0] luma,
                                          input logic [PIX_W-1:0] edge_value,
                                          input int edge_count, input logic last_of_frame);
      return '{is_write: 1'b0, reg_index: '0, value: CSR_DATA_W'(luma), has_result: 1'b1,
               result: '{edge_value, COUNT_W'(edge_count), last_of_frame}};
   endfunction

   task automatic compute_edge_pixel(input logic [PIX_W-1:0] luma, output logic produced,
                                     output edge_result_type res, output logic frame_end);
      int w, h, gx, gy, mag, r;
      logic [PIX_W-1:0] up2, up1;
      logic line_end;
      w = int'(cfg_width);
      if (w < 3) w = 3;
      else if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      h = int'(cfg_height);
      if (h < 3) h = 3;
      else if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
      up2 = line_mem[col_pos];
      up1 = line_mem[MAX_WIDTH_DEF + col_pos];
      line_end  = int'(col_pos) >= w - 1;
      frame_end = line_end && int'(row_pos) >= h - 1;
      for (r = 0; r < 3; r++) begin
         sobel_win[r*3]     = sobel_win[r*3 + 1];
         sobel_win[r*3 + 1] = sobel_win[r*3 + 2];
      end
      sobel_win[2] = up2;
      sobel_win[5] = up1;
      sobel_win[8] = luma;
      line_mem[col_pos] = up1;
      line_mem[MAX_WIDTH_DEF + col_pos] = luma;
      produced = col_pos >= 2 && row_pos >= 2;
      res = '0;
      if (produced) begin
         gx = (int'(sobel_win[2]) - int'(sobel_win[0]))
            + 2 * (int'(sobel_win[5]) - int'(sobel_win[3]))
            + (int'(sobel_win[8]) - int'(sobel_win[6]));
         gy = (int'(sobel_win[0]) - int'(sobel_win[6]))
            + 2 * (int'(sobel_win[1]) - int'(sobel_win[7]))
            + (int'(sobel_win[2]) - int'(sobel_win[8]));
         mag = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
         if (mag > int'(cfg_thr)) begin
            res.edge_value = EDGE_ON;
            if (frame_edges != '1) frame_edges++;
         end else begin
            res.edge_value = EDGE_OFF;
         end
         res.edge_count    = frame_edges;
         res.last_of_frame = frame_end;
      end
      if (frame_end) begin
         col_pos     = '0;
         row_pos     = '0;
         frame_edges = '0;
      end else if (line_end) begin
         col_pos = '0;
         row_pos++;
      end else begin
         col_pos++;
      end
   endtask

   task automatic feed_pixel(input logic [PIX_W-1:0] luma, input logic typed,
                             input edge_result_type typed_res, output logic frame_end);
      logic produced;
      edge_result_type res;
      int gap;
      compute_edge_pixel(luma, produced, res, frame_end);
      if (produced) expected_edges.push_back(typed ? typed_res : res);
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= luma;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      settle_block();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:    cfg_width  = data[WIDTH_REG_W-1:0];
         CSR_FRAME_HEIGHT:   cfg_height = data[HEIGHT_REG_W-1:0];
         CSR_EDGE_THRESHOLD: cfg_thr    = data[THR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic run_frame(input logic counted);
      int n, poke_at;
      logic done;
      logic [PIX_W-1:0] luma;
      texture_type texture;
      texture = texture_type'($urandom_range(0, 3));
      poke_at = (counted && $urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : -1;
      n = 0;
      done = 1'b0;
      while (!done) begin
         if (n == poke_at) begin
            case ($urandom_range(0, 3))
               0, 1: write_reg(CSR_EDGE_THRESHOLD, CSR_DATA_W'($urandom_range(0, 2047)));
               2:    write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'($urandom_range(0, 8)));
               default: write_reg(CSR_FRAME_HEIGHT, 13'h1FFF);
            endcase
         end
         // A very tall frame is cut short by lowering the height in mid-frame.
         if (n == 400 && cfg_height > 13'd100) write_reg(CSR_FRAME_HEIGHT, 13'd3);
         case (texture)
            TEXTURE_NOISE: luma = PIX_W'($urandom_range(0, 255));
            TEXTURE_BINARY: luma = ($urandom_range(0, 1) != 0) ? EDGE_ON : EDGE_OFF;
            default: begin
               luma_walk += int'($urandom_range(0, 16)) - 8;
               if (luma_walk < 0) luma_walk = 0;
               else if (luma_walk > 255) luma_walk = 255;
               luma = PIX_W'(luma_walk);
               if (texture == TEXTURE_SPIKES && $urandom_range(0, 7) == 0)
                  luma = PIX_W'($urandom_range(0, 255));
            end
         endcase
         feed_pixel(luma, 1'b0, '0, done);
         n++;
         if (counted) random_pixels++;
      end
   endtask

   always @(posedge clock) begin : result_side
      edge_result_type got, want;
      int gap;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[30:8], rsp_tlast};
            if (expected_edges.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transaction: value %0d count %0d last %0d",
                           got.edge_value, got.edge_count, got.last_of_frame);
            end else begin
               want = expected_edges.pop_front();
               if (got.edge_value !== want.edge_value || got.edge_count !== want.edge_count
                   || got.last_of_frame !== want.last_of_frame) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected value %0d count %0d last %0d, got %0d %0d %0d",
                              want.edge_value, want.edge_count, want.last_of_frame,
                              got.edge_value, got.edge_count, got.last_of_frame);
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            gap = pick_gap(rsp_quiet);
            rsp_tready <= (gap == 0);
            rsp_hold = (gap > 0) ? gap - 1 : 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      script_row_type script[$];
      logic done;
      int frames;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (sobel_win[i]) sobel_win[i] = '0;
      script = '{
         wr(CSR_FRAME_WIDTH, 13'd2), wr(CSR_FRAME_HEIGHT, 13'd0),
         wr(CSR_EDGE_THRESHOLD, 13'd0),
         px(8'd0), px(8'd0), px(8'd0), px(8'd0), px(8'd0), px(8'd0), px(8'd0), px(8'd0),
         pxe(8'd0, EDGE_OFF, 0, 1'b1),
         px(8'd0), px(8'd0), px(8'd255), px(8'd0),
         wr(CSR_EDGE_THRESHOLD, 13'd1019),
         px(8'd0), px(8'd255), px(8'd0), px(8'd0),
         pxe(8'd255, EDGE_ON, 1, 1'b1),
         wr(CSR_SPARE, 13'h1FFF), wr(CSR_EDGE_THRESHOLD, 13'd1020),
         px(8'd0), px(8'd0), px(8'd255), px(8'd0), px(8'd0), px(8'd255), px(8'd0), px(8'd0),
         pxe(8'd255, EDGE_OFF, 0, 1'b1)
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (script[i]) begin
         if (script[i].is_write)
            write_reg(script[i].reg_index, script[i].value);
         else
            feed_pixel(script[i].value[PIX_W-1:0], script[i].has_result, script[i].result, done);
      end
      while (random_pixels < RANDOM_PIXELS) begin
         req_quiet = ($urandom_range(0, 4) == 0);
         rsp_quiet = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0:       write_reg(CSR_FRAME_WIDTH, CSR_DATA_W'($urandom_range(0, 2)));
            1, 2:    write_reg(CSR_FRAME_WIDTH, CSR_DATA_W'($urandom_range(13, 40)));
            default: write_reg(CSR_FRAME_WIDTH, CSR_DATA_W'($urandom_range(3, 12)));
         endcase
         if ($urandom_range(0, 5) == 0)
            write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'($urandom_range(0, 2)));
         else write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'($urandom_range(3, 6)));
         case ($urandom_range(0, 9))
            0:       write_reg(CSR_EDGE_THRESHOLD, 13'd0);
            1:       write_reg(CSR_EDGE_THRESHOLD, 13'd2040);
            2:       write_reg(CSR_EDGE_THRESHOLD, 13'd2047);
            3:       write_reg(CSR_EDGE_THRESHOLD, CSR_DATA_W'($urandom_range(0, 8191)));
            default: write_reg(CSR_EDGE_THRESHOLD, CSR_DATA_W'($urandom_range(0, 700)));
         endcase
         frames = $urandom_range(1, 3);
         repeat (frames) run_frame(1'b1);
      end
      req_tvalid <= 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

endmodule

[sobel_edge_binarize_count_top.f]
rtl/sebc_pkg.sv
rtl/sebc_csr.sv
rtl/sebc_line_store.sv
rtl/sebc_sobel.sv
rtl/sobel_edge_binarize_count_top.sv
sim/tb.sv
